### rtl/pidh_pkg.sv
// Package for the PID heater duty controller: field widths, register
// indexes, result modes and fixed constants. No dependencies.
package pidh_pkg;

  localparam int SAMPLE_W   = 12;
  localparam int GAIN_W     = 16;
  localparam int DUTY_W     = 8;
  localparam int ERR_W      = SAMPLE_W + 1;
  localparam int PERR_W     = 14;
  localparam int INTEG_W    = 32;
  localparam int RES_W      = 49;
  localparam int CFG_IDX_W  = 4;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 8;
  localparam int OUT_USER_W = 8;

  localparam logic [DUTY_W-1:0]    RESET_DUTY     = 8'd192;
  localparam logic [DUTY_W-1:0]    FULL_DUTY      = 8'hFF;
  localparam logic [GAIN_W-1:0]    RESET_GAIN_P   = 16'd100;
  localparam logic [GAIN_W-1:0]    RESET_GAIN_I   = 16'd5;
  localparam logic [GAIN_W-1:0]    RESET_GAIN_D   = 16'd0;
  localparam logic signed [ERR_W-1:0] PREHEAT_MARGIN = 13'sd100;
  localparam logic signed [RES_W-1:0] OUT_MAX        = 49'sd65535;

  typedef enum logic [1:0] {
    MODE_OFF     = 2'd0,
    MODE_PREHEAT = 2'd1,
    MODE_HOLD    = 2'd2,
    MODE_PID     = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET = 4'd0,
    REG_GAIN_P = 4'd1,
    REG_GAIN_I = 4'd2,
    REG_GAIN_D = 4'd3
  } cfg_reg_t;

endpackage

### rtl/pid_heater_duty_controller.sv
// PID heater duty controller: one sample word in, one duty word out.
// Depends on pidh_pkg for widths, register indexes and mode codes.
//
// Usage. Samples arrive on the in_ stream, one 12-bit ADC value per word.
// Each sample gives exactly one result word on the out_ stream: the duty
// (0 to 255) in out_tdata and the mode in out_tuser (off, full preheat,
// preheat reached and held, PID). Gains and the target are written on the
// cfg_ channel, which is always ready; a target write clears the integral
// and the preheat flag. Writes must be made only while no sample is in
// flight; the block itself does not enforce this. An accepted sample is
// registered, then the three gain multiplications, the sum, the clamp and
// the integrator update run into the output register. One word is accepted
// per cycle while the receiver takes each result; the rate is set by that
// single update step, since each sample needs the integral left by the last.
// After reset the target is zero (heater off), the gains are 100, 5 and 0,
// the integral and previous error are zero and the held duty is 192.
// When the receiver stalls, the output register holds its word and the
// input register fills; in_tready falls only once both are occupied.
module pid_heater_duty_controller (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [pidh_pkg::IN_DATA_W-1:0]      in_tdata,   // [11:0] sample
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [pidh_pkg::OUT_DATA_W-1:0]     out_tdata,  // [7:0] duty
  output logic [pidh_pkg::OUT_USER_W-1:0]     out_tuser,  // [1:0] mode
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pidh_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pidh_pkg::GAIN_W-1:0]         cfg_wdata
);

  logic                                     in_valid_r;
  logic [pidh_pkg::SAMPLE_W-1:0]            sample_r;
  logic                                     out_valid_r;
  logic [pidh_pkg::DUTY_W-1:0]              duty_r;
  pidh_pkg::mode_t                          mode_r;

  logic [pidh_pkg::SAMPLE_W-1:0]            target_r;
  logic signed [pidh_pkg::GAIN_W-1:0]       gain_p_r;
  logic signed [pidh_pkg::GAIN_W-1:0]       gain_i_r;
  logic signed [pidh_pkg::GAIN_W-1:0]       gain_d_r;
  logic signed [pidh_pkg::INTEG_W-1:0]      integral_r;
  logic signed [pidh_pkg::PERR_W-1:0]       prev_err_r;
  logic                                     preheat_r;
  logic [pidh_pkg::DUTY_W-1:0]              held_r;

  logic                                     adv;
  logic                                     cfg_wr;
  logic signed [pidh_pkg::ERR_W-1:0]        err;
  logic signed [pidh_pkg::PERR_W-1:0]       diff;
  logic signed [28:0]                       prod_p;
  logic signed [47:0]                       prod_i;
  logic signed [29:0]                       prod_d;
  logic signed [pidh_pkg::RES_W-1:0]        res;
  logic                                     res_over;
  logic                                     res_neg;
  logic                                     int_en;
  logic signed [pidh_pkg::INTEG_W:0]        isum;
  logic signed [pidh_pkg::INTEG_W-1:0]      isum_sat;
  logic [pidh_pkg::DUTY_W-1:0]              pid_duty;

  logic [pidh_pkg::DUTY_W-1:0]              duty_nxt;
  pidh_pkg::mode_t                          mode_nxt;
  logic [pidh_pkg::DUTY_W-1:0]              held_nxt;
  logic                                     preheat_nxt;
  logic signed [pidh_pkg::INTEG_W-1:0]      integral_nxt;
  logic signed [pidh_pkg::PERR_W-1:0]       prev_err_nxt;

  assign adv       = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || adv;
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = duty_r;
  assign out_tuser  = {{(pidh_pkg::OUT_USER_W-2){1'b0}}, mode_r};

  always_comb begin
    err    = $signed({1'b0, sample_r}) - $signed({1'b0, target_r});
    diff   = $signed({err[pidh_pkg::ERR_W-1], err}) - prev_err_r;
    prod_p = gain_p_r * err;
    prod_i = gain_i_r * integral_r;
    prod_d = gain_d_r * diff;
    res    = pidh_pkg::RES_W'(prod_p) + pidh_pkg::RES_W'(prod_i)
           + pidh_pkg::RES_W'(prod_d);
    res_over = res > pidh_pkg::OUT_MAX;
    res_neg  = res[pidh_pkg::RES_W-1];
    int_en = (!err[pidh_pkg::ERR_W-1] && (err != '0) && !res_over)
          || (err[pidh_pkg::ERR_W-1] && !res_neg);
    isum = $signed({integral_r[pidh_pkg::INTEG_W-1], integral_r})
         + $signed({{(pidh_pkg::INTEG_W+1-pidh_pkg::ERR_W){err[pidh_pkg::ERR_W-1]}}, err});
    if (isum[pidh_pkg::INTEG_W] != isum[pidh_pkg::INTEG_W-1]) begin
      isum_sat = isum[pidh_pkg::INTEG_W] ? {1'b1, {(pidh_pkg::INTEG_W-1){1'b0}}}
                                         : {1'b0, {(pidh_pkg::INTEG_W-1){1'b1}}};
    end else begin
      isum_sat = isum[pidh_pkg::INTEG_W-1:0];
    end
    if (res_neg) begin
      pid_duty = '0;
    end else if (res_over) begin
      pid_duty = pidh_pkg::FULL_DUTY;
    end else begin
      pid_duty = res[15:8];
    end

    duty_nxt     = held_r;
    mode_nxt     = pidh_pkg::MODE_HOLD;
    held_nxt     = held_r;
    preheat_nxt  = preheat_r;
    integral_nxt = integral_r;
    prev_err_nxt = prev_err_r;
    if (target_r == '0) begin
      duty_nxt = '0;
      mode_nxt = pidh_pkg::MODE_OFF;
      held_nxt = '0;
    end else if (!preheat_r) begin
      if (err > pidh_pkg::PREHEAT_MARGIN) begin
        duty_nxt = pidh_pkg::FULL_DUTY;
        mode_nxt = pidh_pkg::MODE_PREHEAT;
        held_nxt = pidh_pkg::FULL_DUTY;
      end else begin
        preheat_nxt = 1'b1;
      end
    end else begin
      duty_nxt     = pid_duty;
      mode_nxt     = pidh_pkg::MODE_PID;
      held_nxt     = pid_duty;
      prev_err_nxt = $signed({err[pidh_pkg::ERR_W-1], err});
      if (int_en) begin
        integral_nxt = isum_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      target_r    <= '0;
      gain_p_r    <= pidh_pkg::RESET_GAIN_P;
      gain_i_r    <= pidh_pkg::RESET_GAIN_I;
      gain_d_r    <= pidh_pkg::RESET_GAIN_D;
      integral_r  <= '0;
      prev_err_r  <= '0;
      preheat_r   <= 1'b0;
      held_r      <= pidh_pkg::RESET_DUTY;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
        prev_err_r  <= prev_err_nxt;
        held_r      <= held_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr && cfg_index == pidh_pkg::REG_TARGET) begin
        integral_r <= '0;
        preheat_r  <= 1'b0;
      end else if (adv) begin
        integral_r <= integral_nxt;
        preheat_r  <= preheat_nxt;
      end
      if (cfg_wr) begin
        unique case (cfg_index)
          pidh_pkg::REG_TARGET: target_r <= cfg_wdata[pidh_pkg::SAMPLE_W-1:0];
          pidh_pkg::REG_GAIN_P: gain_p_r <= cfg_wdata;
          pidh_pkg::REG_GAIN_I: gain_i_r <= cfg_wdata;
          pidh_pkg::REG_GAIN_D: gain_d_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      sample_r <= in_tdata[pidh_pkg::SAMPLE_W-1:0];
    end
    if (adv) begin
      duty_r <= duty_nxt;
      mode_r <= mode_nxt;
    end
  end

  a_off_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && mode_r == pidh_pkg::MODE_OFF |-> duty_r == '0)
    else $error("off mode with nonzero duty");

  a_preheat_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && mode_r == pidh_pkg::MODE_PREHEAT |-> duty_r == pidh_pkg::FULL_DUTY)
    else $error("full preheat without full duty");

  a_target_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr && cfg_index == pidh_pkg::REG_TARGET |=> !preheat_r && integral_r == '0)
    else $error("target write did not clear controller state");

  a_integ_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv && !cfg_wr |=> $stable(integral_r) && $stable(prev_err_r))
    else $error("controller state changed without an update");

endmodule
